@@ hdl/crfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package crfc_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W   = 3;
  localparam int CNT_IW  = 5;
  localparam int MASK_W  = 3;
  localparam int STAT_W  = 3;
  localparam int FILL_OW = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CNT_IW-1:0] MAX_BATCH = 5'd16;
  localparam logic [CNT_IW-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_SEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RECV  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BATCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POLL  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_EOS    = 3'd1;
  localparam logic [STAT_W-1:0] ST_PIPE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BLOCK  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOSUP  = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLOSED = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_EN = 1'd1;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              close;
    logic              poll;
    logic              emit;
    logic              last;
    logic [STAT_W-1:0] status;
  } ctl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic              closed;
    logic              batch_en;
    logic [CNT_IW-1:0] avail;
  } stat_t;

endpackage
`default_nettype wire

@@ hdl/crfc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module crfc_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [crfc_pkg::CMD_W-1:0]  in_command,
  input  wire logic [crfc_pkg::CNT_IW-1:0] in_count,
  input  wire crfc_pkg::stat_t           stat,
  output crfc_pkg::ctl_t                 ctl,
  output logic                           busy
);
  import crfc_pkg::*;

  typedef enum logic {IDLE, BATCH} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_IW-1:0] rem_r, rem_nxt;
  logic [CNT_IW-1:0] n_words;
  logic              accept;

  assign accept  = start && (state_r == IDLE);
  assign busy    = (state_r == BATCH);
  assign n_words = (in_count < stat.avail) ? in_count : stat.avail;

  always_comb begin
    ctl       = '0;
    ctl.last  = 1'b1;
    ctl.status = ST_OK;
    state_nxt = state_r;
    rem_nxt   = rem_r;
    case (state_r)
      IDLE: begin
        if (accept) begin
          ctl.emit = 1'b1;
          case (in_command)
            CMD_SEND: begin
              if (stat.closed) begin
                ctl.status = ST_PIPE;
              end else if (stat.full) begin
                ctl.status = ST_BLOCK;
              end else begin
                ctl.push = 1'b1;
              end
            end
            CMD_RECV: begin
              if (stat.empty) begin
                ctl.status = stat.closed ? ST_EOS : ST_BLOCK;
              end else begin
                ctl.pop = 1'b1;
              end
            end
            CMD_BATCH: begin
              if (stat.closed && stat.empty) begin
                ctl.status = ST_EOS;
              end else if (!stat.batch_en) begin
                ctl.status = ST_NOSUP;
              end else if (stat.empty) begin
                ctl.status = ST_BLOCK;
              end else if (in_count != '0) begin
                ctl.pop  = 1'b1;
                ctl.last = (n_words == CNT_IW'(1));
                if (n_words != CNT_IW'(1)) begin
                  state_nxt = BATCH;
                  rem_nxt   = n_words - CNT_IW'(1);
                end
              end
            end
            CMD_CLOSE: begin
              if (stat.closed) begin
                ctl.status = ST_CLOSED;
              end else begin
                ctl.close = 1'b1;
              end
            end
            CMD_POLL: begin
              ctl.poll = 1'b1;
            end
            default: begin
              ctl.status = ST_NOSUP;
            end
          endcase
        end
      end
      BATCH: begin
        ctl.emit = 1'b1;
        ctl.pop  = 1'b1;
        ctl.last = (rem_r == CNT_IW'(1));
        rem_nxt  = rem_r - CNT_IW'(1);
        if (rem_r == CNT_IW'(1)) begin
          state_nxt = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/crfc_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module crfc_dpath #(
  parameter int DEPTH      = crfc_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = crfc_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [crfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crfc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [DATA_WIDTH-1:0]          in_data_in,
  input  wire logic [crfc_pkg::MASK_W-1:0]    in_event_mask,
  input  wire crfc_pkg::ctl_t                 ctl,
  output crfc_pkg::stat_t                     stat,
  output logic                                out_valid,
  output logic [crfc_pkg::STAT_W-1:0]         out_status,
  output logic [DATA_WIDTH-1:0]               out_data_out,
  output logic                                out_last,
  output logic [crfc_pkg::MASK_W-1:0]         out_events,
  output logic [crfc_pkg::FILL_OW-1:0]        out_fill_level
);
  import crfc_pkg::*;

  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = (CNT_W > CNT_IW) ? CNT_W : CNT_IW;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PW-1:0]     rp_r, rp_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              closed_r, closed_nxt;
  logic [CNT_IW-1:0] cap_r;
  logic              batch_r;
  logic [LW-1:0]     cap_eff;
  logic              full;
  logic [MASK_W-1:0] ev;

  logic                  valid_r;
  logic [STAT_W-1:0]     status_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic                  last_r;
  logic [MASK_W-1:0]     events_r;
  logic [FILL_OW-1:0]    level_r;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [LW-1:0] cap);
    logic [LW-1:0] p1;
    p1 = LW'(p) + LW'(1);
    if (p1 >= cap) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = LW'(1);
    end else if (LW'(cap_r) > LW'(DEPTH)) begin
      cap_eff = LW'(DEPTH);
    end else begin
      cap_eff = LW'(cap_r);
    end
  end

  assign full = (LW'(fill_r) >= cap_eff);

  assign stat.empty    = (fill_r == '0);
  assign stat.full     = full;
  assign stat.closed   = closed_r;
  assign stat.batch_en = batch_r;
  assign stat.avail    = (LW'(fill_r) > LW'(MAX_BATCH)) ? MAX_BATCH : CNT_IW'(fill_r);

  assign ev = {!full && !closed_r, fill_r != '0, closed_r} & in_event_mask;

  always_comb begin
    rp_nxt     = ctl.pop ? advance(rp_r, cap_eff) : rp_r;
    wp_nxt     = ctl.push ? advance(wp_r, cap_eff) : wp_r;
    closed_nxt = closed_r || ctl.close;
    fill_nxt   = fill_r;
    if (ctl.push) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (ctl.pop) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wp_r] <= in_data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r     <= '0;
      wp_r     <= '0;
      fill_r   <= '0;
      closed_r <= 1'b0;
      cap_r    <= CAP_RESET;
      batch_r  <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      closed_r <= closed_nxt;
      valid_r  <= ctl.emit;
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY: cap_r   <= cfg_data;
          REG_BATCH_EN: batch_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status_r <= ctl.status;
      data_r   <= ctl.pop ? mem[rp_r] : '0;
      last_r   <= ctl.last;
      events_r <= ctl.poll ? ev : '0;
      level_r  <= FILL_OW'(fill_nxt);
    end
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_data_out   = data_r;
  assign out_last       = last_r;
  assign out_events     = events_r;
  assign out_fill_level = level_r;

endmodule
`default_nettype wire

@@ hdl/closable_ring_fifo_channel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Bounded ring FIFO of words with a close flag, driven by commands.
// Request channel: set start with in_command, in_data_in, in_count and
// in_event_mask; the request is taken at a clock edge where start is high
// and busy is low. Commands: send, receive, batch receive, close, poll.
// Result channel: each result shows on the out_ ports for one cycle with
// out_valid high; out_last marks the final result of a request.
// A request's first result shows the cycle after the request is taken.
// Throughput: one request per cycle for send, receive, close and poll.
// A batch receive gives one word per cycle, min(count, fill, 16) words, and
// holds busy high until its next-to-last word is out; the storage read port
// sets that rate.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 capacity,
// 1 batch enable) at a clock edge; write only while idle.
// Reset (rst_n low, synchronous) empties and opens the channel, sets
// capacity to 16 and disables batch receive. Storage is not cleared.
// The receiver cannot stall; results must be taken when shown.
module closable_ring_fifo_channel #(
  parameter int DEPTH      = crfc_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = crfc_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [crfc_pkg::CMD_W-1:0]     in_command,
  input  wire logic [DATA_WIDTH-1:0]          in_data_in,
  input  wire logic [crfc_pkg::CNT_IW-1:0]    in_count,
  input  wire logic [crfc_pkg::MASK_W-1:0]    in_event_mask,
  output logic                                out_valid,
  output logic [crfc_pkg::STAT_W-1:0]         out_status,
  output logic [DATA_WIDTH-1:0]               out_data_out,
  output logic                                out_last,
  output logic [crfc_pkg::MASK_W-1:0]         out_events,
  output logic [crfc_pkg::FILL_OW-1:0]        out_fill_level,
  input  wire logic                           cfg_we,
  input  wire logic [crfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crfc_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  crfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .in_count   (in_count),
    .stat       (stat),
    .ctl        (ctl),
    .busy       (busy)
  );

  crfc_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_data_in     (in_data_in),
    .in_event_mask  (in_event_mask),
    .ctl            (ctl),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_last       (out_last),
    .out_events     (out_events),
    .out_fill_level (out_fill_level)
  );

endmodule
`default_nettype wire

@@ dv/crfc_result_checker.sv @@
`timescale 1ns / 1ps
module crfc_result_checker #(
  parameter int DEPTH      = crfc_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = crfc_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [crfc_pkg::CMD_W-1:0]      in_command,
  input  logic [DATA_WIDTH-1:0]           in_data_in,
  input  logic [crfc_pkg::CNT_IW-1:0]     in_count,
  input  logic [crfc_pkg::MASK_W-1:0]     in_event_mask,
  input  logic                            out_valid,
  input  logic [crfc_pkg::STAT_W-1:0]     out_status,
  input  logic [DATA_WIDTH-1:0]           out_data_out,
  input  logic                            out_last,
  input  logic [crfc_pkg::MASK_W-1:0]     out_events,
  input  logic [crfc_pkg::FILL_OW-1:0]    out_fill_level,
  input  logic                            cfg_we,
  input  logic [crfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crfc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            wrap_up,
  output int                              mismatches
);
  import crfc_pkg::*;

  localparam logic [MASK_W-1:0] EV_SHUT     = 3'b001;
  localparam logic [MASK_W-1:0] EV_READABLE = 3'b010;
  localparam logic [MASK_W-1:0] EV_WRITABLE = 3'b100;

  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [DATA_WIDTH-1:0] word;
    logic                  last;
    logic [MASK_W-1:0]     events;
    logic [FILL_OW-1:0]    fill;
  } chan_result_t;

  logic [DATA_WIDTH-1:0] ring_words [DEPTH];
  int                    head_idx;
  int                    tail_idx;
  int                    held;
  bit                    shut;
  logic [CFG_DATA_W-1:0] cap_setting;
  bit                    batch_allowed;
  bit                    wrapped;
  chan_result_t          expected_results [$];

  initial mismatches = 0;

  function automatic int usable_entries();
    int c;
    c = int'(cap_setting);
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int step_ptr(int p);
    return (p + 1 >= usable_entries()) ? 0 : p + 1;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [DATA_WIDTH-1:0] got,
                             logic [DATA_WIDTH-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic queue_result(logic [STAT_W-1:0] st, logic [DATA_WIDTH-1:0] word,
                              logic lst, logic [MASK_W-1:0] ev);
    chan_result_t r;
    r.status = st;
    r.word   = word;
    r.last   = lst;
    r.events = ev;
    r.fill   = FILL_OW'(held);
    expected_results.push_back(r);
  endtask

  task automatic take_word(output logic [DATA_WIDTH-1:0] word);
    word = ring_words[head_idx];
    head_idx = step_ptr(head_idx);
    held--;
  endtask

  task automatic model_request(logic [CMD_W-1:0] cmd, logic [DATA_WIDTH-1:0] din,
                               logic [CNT_IW-1:0] cnt, logic [MASK_W-1:0] mask);
    logic [DATA_WIDTH-1:0] word;
    logic [MASK_W-1:0]     ev;
    int                    n;
    case (cmd)
      CMD_SEND: begin
        if (shut) begin
          queue_result(ST_PIPE, '0, 1'b1, '0);
        end else if (held >= usable_entries()) begin
          queue_result(ST_BLOCK, '0, 1'b1, '0);
        end else begin
          ring_words[tail_idx] = din;
          tail_idx = step_ptr(tail_idx);
          held++;
          queue_result(ST_OK, '0, 1'b1, '0);
        end
      end
      CMD_RECV: begin
        if (held == 0) begin
          queue_result(shut ? ST_EOS : ST_BLOCK, '0, 1'b1, '0);
        end else begin
          take_word(word);
          queue_result(ST_OK, word, 1'b1, '0);
        end
      end
      CMD_BATCH: begin
        if (shut && held == 0) begin
          queue_result(ST_EOS, '0, 1'b1, '0);
        end else if (!batch_allowed) begin
          queue_result(ST_NOSUP, '0, 1'b1, '0);
        end else if (held == 0) begin
          queue_result(ST_BLOCK, '0, 1'b1, '0);
        end else if (cnt == '0) begin
          queue_result(ST_OK, '0, 1'b1, '0);
        end else begin
          n = (int'(cnt) < held) ? int'(cnt) : held;
          if (n > int'(MAX_BATCH)) n = int'(MAX_BATCH);
          for (int i = 0; i < n; i++) begin
            take_word(word);
            queue_result(ST_OK, word, i == n - 1, '0);
          end
        end
      end
      CMD_CLOSE: begin
        if (shut) begin
          queue_result(ST_CLOSED, '0, 1'b1, '0);
        end else begin
          shut = 1'b1;
          queue_result(ST_OK, '0, 1'b1, '0);
        end
      end
      CMD_POLL: begin
        ev = '0;
        if (shut) ev |= EV_SHUT;
        if (held != 0) ev |= EV_READABLE;
        if (held < usable_entries() && !shut) ev |= EV_WRITABLE;
        queue_result(ST_OK, '0, 1'b1, ev & mask);
      end
      default: begin
        queue_result(ST_NOSUP, '0, 1'b1, '0);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    chan_result_t want;
    if (!rst_n) begin
      head_idx      = 0;
      tail_idx      = 0;
      held          = 0;
      shut          = 1'b0;
      cap_setting   = CAP_RESET;
      batch_allowed = 1'b0;
      wrapped       = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_results.pop_front();
          check_field("status", DATA_WIDTH'(out_status), DATA_WIDTH'(want.status));
          check_field("data_out", out_data_out, want.word);
          check_field("last", DATA_WIDTH'(out_last), DATA_WIDTH'(want.last));
          check_field("events", DATA_WIDTH'(out_events), DATA_WIDTH'(want.events));
          check_field("fill_level", DATA_WIDTH'(out_fill_level), DATA_WIDTH'(want.fill));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_CAPACITY) begin
          cap_setting = cfg_data;
        end else if (cfg_index == REG_BATCH_EN) begin
          batch_allowed = cfg_data[0];
        end
      end
      if (start && !busy) model_request(in_command, in_data_in, in_count, in_event_mask);
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (expected_results.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
      end
    end
  end

endmodule

@@ dv/closable_ring_fifo_channel_tb.sv @@
`timescale 1ns / 1ps
module closable_ring_fifo_channel_tb;
  import crfc_pkg::*;

  localparam int DATA_WIDTH = DATA_WIDTH_DEF;
  localparam logic [CMD_W-1:0] CMD_UNDEF_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNDEF_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_C = 3'd7;
  localparam int PHASE_ITEMS = 36;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      in_command    = '0;
  logic [DATA_WIDTH-1:0] in_data_in    = '0;
  logic [CNT_IW-1:0]     in_count      = '0;
  logic [MASK_W-1:0]     in_event_mask = '0;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [DATA_WIDTH-1:0] out_data_out;
  logic                  out_last;
  logic [MASK_W-1:0]     out_events;
  logic [FILL_OW-1:0]    out_fill_level;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  wrap_up       = 1'b0;

  int                    mismatches;
  int                    outstanding   = 0;
  logic [FILL_OW-1:0]    last_fill     = '0;
  logic [CFG_DATA_W-1:0] cur_cap       = CAP_RESET;
  bit                    req_up        = 1'b0;
  int                    idle_pct      = 0;
  int                    random_done   = 0;

  always #1 clk = ~clk;

  closable_ring_fifo_channel dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_data_in     (in_data_in),
    .in_count       (in_count),
    .in_event_mask  (in_event_mask),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_last       (out_last),
    .out_events     (out_events),
    .out_fill_level (out_fill_level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  crfc_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_data_in     (in_data_in),
    .in_count       (in_count),
    .in_event_mask  (in_event_mask),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_last       (out_last),
    .out_events     (out_events),
    .out_fill_level (out_fill_level),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .wrap_up        (wrap_up),
    .mismatches     (mismatches)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      outstanding <= 0;
    end else begin
      outstanding <= outstanding + ((start && !busy) ? 1 : 0)
                     - ((out_valid && out_last) ? 1 : 0);
    end
    if (out_valid) last_fill <= out_fill_level;
  end

  task automatic issue(logic [CMD_W-1:0] cmd, logic [DATA_WIDTH-1:0] word,
                       logic [CNT_IW-1:0] cnt, logic [MASK_W-1:0] mask);
    if ($urandom_range(0, 99) < idle_pct) begin
      if (req_up) start <= 1'b0;
      req_up = 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start         <= 1'b1;
    req_up        = 1'b1;
    in_command    <= cmd;
    in_data_in    <= word;
    in_count      <= cnt;
    in_event_mask <= mask;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    if (req_up) start <= 1'b0;
    req_up = 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic empty_ring();
    settle();
    while (last_fill != '0) begin
      issue(CMD_RECV, $urandom, '0, '0);
      settle();
    end
  endtask

  // drain before a capacity change so that no stale entry is ever read
  task automatic set_config(logic [CFG_DATA_W-1:0] cap, logic ben);
    if (cap != cur_cap) empty_ring();
    else settle();
    cur_cap = cap;
    cfg_we    <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_index <= REG_BATCH_EN;
    cfg_data  <= CFG_DATA_W'(ben);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item(int send_pct, bit may_close);
    int                    pick;
    int                    sel;
    logic [CMD_W-1:0]      cmd;
    logic [DATA_WIDTH-1:0] word;
    logic [CNT_IW-1:0]     cnt;
    idle_pct = (random_done < 91) ? 13 : ((random_done < 182) ? 54 : 0);
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    if (pick < send_pct) begin
      cmd = CMD_SEND;
    end else if (sel < 35) begin
      cmd = CMD_RECV;
    end else if (sel < 70) begin
      cmd = CMD_BATCH;
    end else if (sel < 86) begin
      cmd = CMD_POLL;
    end else if (sel < 90) begin
      cmd = may_close ? CMD_CLOSE : CMD_POLL;
    end else begin
      case ($urandom_range(0, 2))
        0: cmd = CMD_UNDEF_A;
        1: cmd = CMD_UNDEF_B;
        default: cmd = CMD_UNDEF_C;
      endcase
    end
    cnt = ($urandom_range(0, 9) < 7) ? CNT_IW'($urandom_range(0, 6)) : CNT_IW'($urandom);
    sel = $urandom_range(0, 99);
    word = (sel < 8) ? '0 : ((sel < 16) ? '1 : DATA_WIDTH'($urandom));
    issue(cmd, word, cnt, MASK_W'($urandom));
    random_done++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 13;

    // capacity zero holds a single word
    set_config('0, 1'b1);
    issue(CMD_SEND, '0, '0, '0);
    issue(CMD_SEND, '1, '1, '1);
    issue(CMD_POLL, '0, '0, '1);
    issue(CMD_BATCH, '1, '0, '0);
    issue(CMD_BATCH, '0, '1, '0);
    issue(CMD_RECV, '1, '0, '0);
    issue(CMD_BATCH, '0, CNT_IW'(1), '0);
    issue(CMD_POLL, '0, '0, '1);
    issue(CMD_UNDEF_C, '1, '1, '1);
    issue(CMD_UNDEF_A, '0, '0, '0);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(CAP_RESET, 1'b1);
        1: set_config('1, 1'b1);
        2: set_config(CFG_DATA_W'(1), 1'b1);
        3: set_config(CFG_DATA_W'($urandom_range(2, 15)), 1'b0);
        4: set_config(CFG_DATA_W'(2), 1'b1);
        5: set_config(CFG_DATA_W'($urandom_range(1, 16)), 1'($urandom));
        default: set_config(CAP_RESET, 1'b1);
      endcase
      repeat (PHASE_ITEMS) random_item((p == 1 || p == 6) ? 65 : 45, 1'b0);
    end

    // close with words still held
    set_config(CAP_RESET, 1'b0);
    issue(CMD_SEND, $urandom, '0, '0);
    issue(CMD_SEND, $urandom, '0, '0);
    issue(CMD_CLOSE, '0, '0, '0);
    issue(CMD_SEND, $urandom, '0, '0);
    issue(CMD_CLOSE, '0, '0, '0);
    issue(CMD_BATCH, '0, CNT_IW'(3), '0);
    issue(CMD_POLL, '0, '0, '1);
    set_config(CAP_RESET, 1'b1);
    issue(CMD_BATCH, '0, CNT_IW'(2), '0);
    issue(CMD_BATCH, '0, '1, '0);
    issue(CMD_RECV, '0, '0, '0);
    issue(CMD_BATCH, '0, CNT_IW'(1), '0);
    issue(CMD_POLL, '0, '0, '1);
    set_config(CAP_RESET, 1'b0);
    issue(CMD_BATCH, '0, CNT_IW'(1), '0);
    repeat (20) random_item(30, 1'b1);

    settle();
    repeat (10) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/crfc_pkg.sv
hdl/crfc_ctrl.sv
hdl/crfc_dpath.sv
hdl/closable_ring_fifo_channel.sv
dv/crfc_result_checker.sv
dv/closable_ring_fifo_channel_tb.sv
